>>> rtl/core/atfpe_pkg.sv
// Shared types, character codes and encodings for the assembly text first-pass encoder.
package atfpe_pkg;

    // Beat on the character side: one character of text per beat.
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in_beat;

    // Beat on the record side.
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] record_data;
        logic        last_of_run;
    } t_out_beat;

    // Open instruction, or the mnemonic a token names.
    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_ORIG = 3'd1,
        KIND_AND  = 3'd2,
        KIND_ADD  = 3'd3,
        KIND_TRAP = 3'd4,
        KIND_STR  = 3'd5,
        KIND_NOT  = 3'd6,
        KIND_LD   = 3'd7
    } t_kind;

    // A finished token, or an end-of-text marker, passed from front to back.
    typedef struct packed {
        logic        has_token;
        logic        eot;
        t_kind       cls;
        logic [2:0]  reg_val;
        logic [15:0] hex_val;
        logic [15:0] dec_val;
        logic        hash;
        logic [15:0] start;
    } t_token;

    // Record kinds.
    localparam logic [1:0] REC_WORD  = 2'd0;
    localparam logic [1:0] REC_LABEL = 2'd1;
    localparam logic [1:0] REC_USAGE = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Mnemonic text, first character in the low byte.
    localparam logic [39:0] MN_ORIG = 40'h47_49_52_4F_2E;
    localparam logic [39:0] MN_AND  = 40'h00_00_44_4E_41;
    localparam logic [39:0] MN_ADD  = 40'h00_00_44_44_41;
    localparam logic [39:0] MN_TRAP = 40'h00_50_41_52_54;
    localparam logic [39:0] MN_STR  = 40'h00_00_52_54_53;
    localparam logic [39:0] MN_NOT  = 40'h00_00_54_4F_4E;
    localparam logic [39:0] MN_LD   = 40'h00_00_00_44_4C;

    localparam logic [3:0] LEN_ORIG = 4'd5;
    localparam logic [3:0] LEN_AND  = 4'd3;
    localparam logic [3:0] LEN_ADD  = 4'd3;
    localparam logic [3:0] LEN_TRAP = 4'd4;
    localparam logic [3:0] LEN_STR  = 4'd3;
    localparam logic [3:0] LEN_NOT  = 4'd3;
    localparam logic [3:0] LEN_LD   = 4'd2;
    localparam logic [3:0] LEN_MAX  = 4'd15;

    // Opcode fields.
    localparam logic [15:0] OPC_AND  = 16'h5000;
    localparam logic [15:0] OPC_ADD  = 16'h1000;
    localparam logic [15:0] OPC_TRAP = 16'hF000;
    localparam logic [15:0] OPC_STR  = 16'h7000;
    localparam logic [15:0] OPC_NOT  = 16'h903F;
    localparam logic [15:0] OPC_LD   = 16'h2000;
    localparam logic [15:0] IMM5_MASK = 16'h001F;
    localparam logic [15:0] IMM_FLAG  = 16'h0020;
    localparam logic [15:0] OFF6_MASK = 16'h003F;

    // Token queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_BITS = 2;

    // Value of one hex digit; anything else reads as zero.
    function automatic logic [3:0] hex_digit(input logic [7:0] c);
        logic [3:0] d;
        d = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d = 4'(c - 8'h57);
        end
        return d;
    endfunction

    // Word bits that opening an instruction sets.
    function automatic logic [15:0] opcode_base(input t_kind k);
        logic [15:0] w;
        case (k)
            KIND_AND:  w = OPC_AND;
            KIND_ADD:  w = OPC_ADD;
            KIND_TRAP: w = OPC_TRAP;
            KIND_STR:  w = OPC_STR;
            KIND_NOT:  w = OPC_NOT;
            KIND_LD:   w = OPC_LD;
            default:   w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/core/assembly_text_first_pass_encoder.sv
// First pass of a small LC-3 assembler: text characters in, first-pass records out.
//
// The block takes one character of assembly text per beat and produces the
// record stream of an assembler's first pass: encoded words for .ORIG, ADD,
// AND, NOT, TRAP, STR and LD, a label declaration record for every token that
// stands where a mnemonic is expected, and a label usage record just before
// each LD word. Label records carry the text position of the token's first
// character, counted from zero at the start of the text and again after every
// end-of-text character. The front part tokenizes and classifies one
// character per clock cycle while the queue has room; each finished token enters a
// four-entry queue, and the back part takes one token per cycle while its output
// register and pending slot are free, to build the instruction words. A record
// passes through the token queue and the output register after the character
// that finishes its token. The sustained rate is one character per cycle; the
// output register is the only narrow point, since a character that completes an
// LD takes two output beats, usage record first. The input stalls only while the
// token queue is full, which happens when the record side has stalled for a
// while. last_of_run marks the final record caused by one character, and end of
// text drops an instruction still open and returns the block to its reset state.
module assembly_text_first_pass_encoder #(
    parameter int POSITION_BITS  = 16,
    parameter int MNEMONIC_CHARS = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  atfpe_pkg::t_in_beat  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output atfpe_pkg::t_out_beat o_out_data
);
    import atfpe_pkg::*;

    logic   in_accept;
    logic   push;
    logic   pop;
    logic   q_empty;
    logic   q_full;
    t_token front_tok;
    t_token head_tok;

    // A character is taken whenever the queue has room for the token it may finish.
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    atfpe_front #(
        .POSITION_BITS  (POSITION_BITS),
        .MNEMONIC_CHARS (MNEMONIC_CHARS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_char   (i_in_data),
        .o_push   (push),
        .o_token  (front_tok)
    );

    atfpe_tok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_tok),
        .i_pop   (pop),
        .o_data  (head_tok),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The back part drains the queue and owns the output register.
    atfpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_avail (!q_empty),
        .i_token     (head_tok),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/core/atfpe_front.sv
// Front part: splits the character stream into tokens and classifies each finished token.
module atfpe_front #(
    parameter int POSITION_BITS  = 16,
    parameter int MNEMONIC_CHARS = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  atfpe_pkg::t_in_beat i_char,
    output logic               o_push,
    output atfpe_pkg::t_token  o_token
);
    import atfpe_pkg::*;

    localparam int PREFIX_BITS = 8 * MNEMONIC_CHARS;

    logic                     r_in_comment, n_in_comment;
    logic                     r_active, n_active;
    logic [3:0]               r_len, n_len;
    logic [PREFIX_BITS-1:0]   r_prefix, n_prefix;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [15:0]              r_hex, n_hex;
    logic [15:0]              r_dec, n_dec;
    logic                     r_minus, n_minus;

    logic [7:0]               c;
    logic                     eot;
    logic                     is_tok;
    logic                     finish;
    logic                     tk_active;
    logic [3:0]               tk_len;
    logic [PREFIX_BITS-1:0]   tk_prefix;
    logic [POSITION_BITS-1:0] tk_start;
    logic [15:0]              tk_hex, tk_dec;
    logic                     tk_minus;
    t_kind                    cls;

    always_comb begin
        c            = i_char.char_code;
        eot          = i_char.end_of_text;
        is_tok       = 1'b0;
        n_in_comment = r_in_comment;
        if (r_in_comment) begin
            if (c == CH_NL) begin
                n_in_comment = 1'b0;
            end
        end else if (c == CH_SEMI) begin
            n_in_comment = 1'b1;
        end else if (c != CH_SPACE && c != CH_NL && c != CH_TAB && c != CH_COMMA) begin
            is_tok = 1'b1;
        end

        tk_active = r_active;
        tk_len    = r_len;
        tk_prefix = r_prefix;
        tk_start  = r_start;
        tk_hex    = r_hex;
        tk_dec    = r_dec;
        tk_minus  = r_minus;
        if (is_tok) begin
            if (!r_active) begin
                tk_len    = 4'd0;
                tk_prefix = '0;
                tk_start  = r_pos;
                tk_hex    = 16'd0;
                tk_dec    = 16'd0;
                tk_minus  = 1'b0;
            end
            for (int i = 0; i < MNEMONIC_CHARS; i++) begin
                if (tk_len == 4'(i)) begin
                    tk_prefix[8*i +: 8] = c;
                end
            end
            if (tk_len != 4'd0) begin
                tk_hex = {tk_hex[11:0], hex_digit(c)};
                if (tk_len == 4'd1 && c == CH_MINUS) begin
                    tk_minus = 1'b1;
                end else begin
                    tk_dec = (tk_dec << 3) + (tk_dec << 1) + {8'h00, c} - {8'h00, CH_ZERO};
                end
            end
            if (tk_len != LEN_MAX) begin
                tk_len = tk_len + 4'd1;
            end
            tk_active = 1'b1;
        end
        finish = tk_active && (!is_tok || eot);

        cls = KIND_NONE;
        if (tk_len == LEN_ORIG && tk_prefix == PREFIX_BITS'(MN_ORIG)) begin
            cls = KIND_ORIG;
        end else if (tk_len == LEN_AND && tk_prefix == PREFIX_BITS'(MN_AND)) begin
            cls = KIND_AND;
        end else if (tk_len == LEN_ADD && tk_prefix == PREFIX_BITS'(MN_ADD)) begin
            cls = KIND_ADD;
        end else if (tk_len == LEN_TRAP && tk_prefix == PREFIX_BITS'(MN_TRAP)) begin
            cls = KIND_TRAP;
        end else if (tk_len == LEN_STR && tk_prefix == PREFIX_BITS'(MN_STR)) begin
            cls = KIND_STR;
        end else if (tk_len == LEN_NOT && tk_prefix == PREFIX_BITS'(MN_NOT)) begin
            cls = KIND_NOT;
        end else if (tk_len == LEN_LD && tk_prefix == PREFIX_BITS'(MN_LD)) begin
            cls = KIND_LD;
        end

        o_push            = i_accept && (finish || eot);
        o_token.has_token = finish;
        o_token.eot       = eot;
        o_token.cls       = cls;
        // The register number is the second character minus '0'; as '0' is a
        // multiple of eight, its low three bits are the character's own.
        o_token.reg_val   = tk_prefix[10:8];
        o_token.hex_val   = tk_hex;
        o_token.dec_val   = tk_minus ? (16'd0 - tk_dec) : tk_dec;
        o_token.hash      = (tk_prefix[7:0] == CH_HASH);
        o_token.start     = 16'(tk_start);

        if (eot) begin
            n_in_comment = 1'b0;
            n_active     = 1'b0;
            n_len        = 4'd0;
            n_prefix     = '0;
            n_start      = '0;
            n_pos        = '0;
            n_hex        = 16'd0;
            n_dec        = 16'd0;
            n_minus      = 1'b0;
        end else begin
            n_active = tk_active && !finish;
            n_len    = tk_len;
            n_prefix = tk_prefix;
            n_start  = tk_start;
            n_pos    = r_pos + POSITION_BITS'(1);
            n_hex    = tk_hex;
            n_dec    = tk_dec;
            n_minus  = tk_minus;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment <= 1'b0;
            r_active     <= 1'b0;
            r_len        <= 4'd0;
            r_prefix     <= '0;
            r_start      <= '0;
            r_pos        <= '0;
            r_hex        <= 16'd0;
            r_dec        <= 16'd0;
            r_minus      <= 1'b0;
        end else if (i_accept) begin
            r_in_comment <= n_in_comment;
            r_active     <= n_active;
            r_len        <= n_len;
            r_prefix     <= n_prefix;
            r_start      <= n_start;
            r_pos        <= n_pos;
            r_hex        <= n_hex;
            r_dec        <= n_dec;
            r_minus      <= n_minus;
        end
    end

endmodule

>>> rtl/core/atfpe_tok_queue.sv
// Short queue of finished tokens between the front and back parts.
module atfpe_tok_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  atfpe_pkg::t_token i_data,
    input  logic              i_pop,
    output atfpe_pkg::t_token o_data,
    output logic              o_empty,
    output logic              o_full
);
    import atfpe_pkg::*;

    t_token                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_PTR_BITS:0]   r_count, n_count;
    logic                      do_push, do_pop;

    always_comb begin
        o_empty  = (r_count == '0);
        o_full   = (r_count == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
        do_push  = i_push && !o_full;
        do_pop   = i_pop && !o_empty;
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
        o_data = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> rtl/core/atfpe_back.sv
// Back part: assembles instruction words from tokens and delivers the records.
module atfpe_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tok_avail,
    input  atfpe_pkg::t_token   i_token,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output atfpe_pkg::t_out_beat o_out_data
);
    import atfpe_pkg::*;

    t_kind       r_kind, n_kind;
    logic [2:0]  r_idx, n_idx;
    logic [15:0] r_word, n_word;
    logic        r_out_valid, n_out_valid;
    t_out_beat   r_out, n_out;
    logic        r_pend_valid, n_pend_valid;
    t_out_beat   r_pend, n_pend;

    logic        out_free;
    logic [1:0]  rec_n;
    t_out_beat   rec0, rec1;
    logic [15:0] w;
    logic        done;
    logic        usage;
    logic [15:0] reg9, reg6, reg0;

    always_comb begin
        reg9 = {4'd0, i_token.reg_val, 9'd0};
        reg6 = {7'd0, i_token.reg_val, 6'd0};
        reg0 = {13'd0, i_token.reg_val};

        w    = r_word;
        done = 1'b0;
        case (r_kind)
            KIND_ORIG: begin
                if (r_idx == 3'd1) begin
                    w = r_word | i_token.hex_val;
                end
                done = 1'b1;
            end
            KIND_AND, KIND_ADD: begin
                if (r_idx == 3'd1) begin
                    w = r_word | reg9;
                end else if (r_idx == 3'd2) begin
                    w = r_word | reg6;
                end else if (i_token.hash) begin
                    w = r_word | (i_token.dec_val & IMM5_MASK) | IMM_FLAG;
                end else begin
                    w = r_word | reg0;
                end
                done = (r_idx >= 3'd3);
            end
            KIND_TRAP: begin
                w    = r_word | i_token.hex_val;
                done = 1'b1;
            end
            KIND_STR: begin
                if (r_idx == 3'd1) begin
                    w = r_word | reg9;
                end else if (r_idx == 3'd2) begin
                    w = r_word | reg6;
                end else begin
                    w = r_word | (i_token.dec_val & OFF6_MASK);
                end
                done = (r_idx >= 3'd3);
            end
            KIND_NOT: begin
                w    = (r_idx == 3'd1) ? (r_word | reg9) : (r_word | reg6);
                done = (r_idx >= 3'd2);
            end
            KIND_LD: begin
                if (r_idx == 3'd1) begin
                    w = r_word | reg9;
                end
                done = (r_idx >= 3'd2);
            end
            default: begin
                done = 1'b1;
            end
        endcase
        usage = (r_kind == KIND_LD) && (r_idx == 3'd2);

        // Records that the token at the queue head causes, in order.
        rec_n  = 2'd0;
        rec0   = '0;
        rec1   = '0;
        n_kind = r_kind;
        n_idx  = r_idx;
        n_word = r_word;
        if (i_token.has_token) begin
            if (r_kind == KIND_NONE) begin
                if (i_token.cls == KIND_NONE) begin
                    rec_n = 2'd1;
                    rec0  = '{record_kind: REC_LABEL, record_data: i_token.start,
                              last_of_run: 1'b1};
                end else begin
                    n_kind = i_token.cls;
                    n_word = opcode_base(i_token.cls);
                    n_idx  = 3'd1;
                end
            end else begin
                n_word = w;
                if (usage) begin
                    rec_n = 2'd1;
                    rec0  = '{record_kind: REC_USAGE, record_data: i_token.start,
                              last_of_run: 1'b1};
                end
                if (done) begin
                    if (usage) begin
                        rec0.last_of_run = 1'b0;
                        rec1  = '{record_kind: REC_WORD, record_data: w, last_of_run: 1'b1};
                        rec_n = 2'd2;
                    end else begin
                        rec0  = '{record_kind: REC_WORD, record_data: w, last_of_run: 1'b1};
                        rec_n = 2'd1;
                    end
                    n_kind = KIND_NONE;
                    n_idx  = 3'd0;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
        end
        // End of text drops an open instruction.
        if (i_token.eot) begin
            n_kind = KIND_NONE;
            n_idx  = 3'd0;
            n_word = 16'd0;
        end

        // A token is taken only when both of its records have room.
        out_free     = !r_out_valid || !i_out_stall;
        o_pop        = i_tok_avail && !r_pend_valid && out_free;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        if (out_free) begin
            if (r_pend_valid) begin
                n_out_valid  = 1'b1;
                n_out        = r_pend;
                n_pend_valid = 1'b0;
            end else if (o_pop && rec_n != 2'd0) begin
                n_out_valid  = 1'b1;
                n_out        = rec0;
                n_pend_valid = (rec_n == 2'd2);
                n_pend       = rec1;
            end else begin
                n_out_valid = 1'b0;
            end
        end

        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind       <= KIND_NONE;
            r_idx        <= 3'd0;
            r_word       <= 16'd0;
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_kind <= n_kind;
                r_idx  <= n_idx;
                r_word <= n_word;
            end
            r_out_valid  <= n_out_valid;
            r_pend_valid <= n_pend_valid;
        end
    end

endmodule

>>> rtl/core/atfpe_checker.sv
// Port-level checks on the first-pass encoder, bound to its top level.
module atfpe_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input atfpe_pkg::t_in_beat  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input atfpe_pkg::t_out_beat o_out_data
);
    import atfpe_pkg::*;

    // A record held back by the receiver stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("record changed while stalled");

    // A usage record is never marked as the last record of its character's run.
    a_usage_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.record_kind == REC_USAGE |-> !o_out_data.last_of_run)
        else $error("usage record marked as last of its run");

    // A label declaration, the only record its character causes, is marked as last of its run.
    a_label_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.record_kind == REC_LABEL |-> o_out_data.last_of_run)
        else $error("label record not marked as last of its run");

    // Nothing is offered in the cycle after a reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("record offered right after reset");

endmodule

bind assembly_text_first_pass_encoder atfpe_checker u_atfpe_checker (.*);
